[rtl/bah_pkg.sv]
// Shared types, codes and field widths of the array heap.
package bah_pkg;

  localparam int OP_W   = 2;
  localparam int REF_W  = 6;
  localparam int IDX_W  = 32;
  localparam int LEN_W  = 13;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_IDX  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_REF  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_ACCESS
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_from_in;
    logic exec;
    logic load_out;
    logic from_mem;
  } bah_cmd_t;

  typedef struct packed {
    logic load_ok;
  } bah_sts_t;

endpackage

[rtl/bah_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bah_ctrl.sv]
// Controller state machine and output valid register of the array heap.
module bah_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  bah_pkg::bah_sts_t sts,
  output bah_pkg::bah_cmd_t cmd
);

  bah_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bah_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      bah_pkg::S_IDLE: begin
        in_tready      = 1'b1;
        cmd.rd_from_in = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = bah_pkg::S_LOOKUP;
        end
      end
      bah_pkg::S_LOOKUP: begin
        if (sts.load_ok) begin
          state_nxt = bah_pkg::S_ACCESS;
        end else if (out_free) begin
          cmd.exec     = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = bah_pkg::S_IDLE;
        end
      end
      bah_pkg::S_ACCESS: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.from_mem = 1'b1;
          state_nxt    = bah_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bah_pkg::S_IDLE;
      end
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[rtl/bah_dp.sv]
// Datapath of the array heap: item registers, slot table, word memory and checks.
module bah_dp #(
  parameter int MAX_ARRAYS = 64,
  parameter int HEAP_WORDS = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bah_pkg::OP_W-1:0]          in_op,
  input  logic [bah_pkg::IN_TDATA_W-1:0]    in_data,
  input  bah_pkg::bah_cmd_t                 cmd,
  output bah_pkg::bah_sts_t                 sts,
  output logic [bah_pkg::OUT_TDATA_W-1:0]   out_data
);

  localparam int SW  = $clog2(MAX_ARRAYS);
  localparam int AW  = $clog2(HEAP_WORDS);
  localparam int NW  = AW + 1;
  localparam int CW  = ((NW > bah_pkg::LEN_W) ? NW : bah_pkg::LEN_W) + 1;
  localparam int RW  = ((SW + 1) > bah_pkg::REF_W) ? (SW + 1) : bah_pkg::REF_W;
  localparam int SEW = NW + bah_pkg::LEN_W;

  logic [bah_pkg::OP_W-1:0]   op_r;
  logic [bah_pkg::REF_W-1:0]  ref_r;
  logic [bah_pkg::IDX_W-1:0]  idx_r;
  logic [bah_pkg::LEN_W-1:0]  len_r;
  logic [bah_pkg::VAL_W-1:0]  val_r;

  logic [SW:0]                slots_used_r, slots_used_nxt;
  logic [NW-1:0]              nfw_r, nfw_nxt;
  logic [bah_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [bah_pkg::REF_W-1:0]  rd_ref;
  logic [SEW-1:0]             slot_rd, slot_wr;
  logic [NW-1:0]              slot_base;
  logic [bah_pkg::LEN_W-1:0]  slot_len;
  logic [bah_pkg::VAL_W-1:0]  elem_rd;

  logic                       ref_bad, idx_bad, addr_bad, full, len_bad;
  logic [CW-1:0]              addr_sum, remaining;
  logic                       alloc_ok, store_ok;
  logic [bah_pkg::STAT_W-1:0] status;
  logic [bah_pkg::REF_W-1:0]  new_ref;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      ref_r <= in_data[5:0];
      idx_r <= in_data[37:6];
      len_r <= in_data[50:38];
      val_r <= in_data[82:51];
    end
    if (cmd.load_out) begin
      if (cmd.from_mem) begin
        out_data_r <= {bah_pkg::ST_OK, elem_rd, {bah_pkg::REF_W{1'b0}}};
      end else begin
        out_data_r <= {status, {bah_pkg::VAL_W{1'b0}}, new_ref};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
      nfw_r        <= '0;
    end else begin
      slots_used_r <= slots_used_nxt;
      nfw_r        <= nfw_nxt;
    end
  end

  assign rd_ref    = cmd.rd_from_in ? in_data[5:0] : ref_r;
  assign slot_base = slot_rd[SEW-1:bah_pkg::LEN_W];
  assign slot_len  = slot_rd[bah_pkg::LEN_W-1:0];
  assign slot_wr   = {nfw_r, len_r};

  assign ref_bad  = RW'(ref_r) >= RW'(slots_used_r);
  assign idx_bad  = (|idx_r[bah_pkg::IDX_W-1:bah_pkg::LEN_W])
                    || (idx_r[bah_pkg::LEN_W-1:0] >= slot_len);
  assign addr_sum = CW'(slot_base) + CW'(idx_r[bah_pkg::LEN_W-1:0]);
  assign addr_bad = addr_sum >= CW'(HEAP_WORDS);

  assign full      = slots_used_r >= (SW + 1)'(MAX_ARRAYS);
  assign remaining = CW'(HEAP_WORDS) - CW'(nfw_r);
  assign len_bad   = CW'(len_r) > remaining;

  assign alloc_ok    = (op_r == bah_pkg::OP_ALLOC) && !full && !len_bad;
  assign store_ok    = (op_r == bah_pkg::OP_STORE) && !ref_bad && !idx_bad && !addr_bad;
  assign sts.load_ok = (op_r == bah_pkg::OP_LOAD) && !ref_bad && !idx_bad && !addr_bad;

  always_comb begin
    status  = bah_pkg::ST_OK;
    new_ref = '0;
    case (op_r)
      bah_pkg::OP_ALLOC: begin
        if (alloc_ok) begin
          new_ref = bah_pkg::REF_W'(slots_used_r);
        end else begin
          status = bah_pkg::ST_FULL;
        end
      end
      bah_pkg::OP_STORE, bah_pkg::OP_LOAD: begin
        if (ref_bad) begin
          status = bah_pkg::ST_BAD_REF;
        end else if (idx_bad || addr_bad) begin
          status = bah_pkg::ST_BAD_IDX;
        end
      end
      default: begin
        status = bah_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    slots_used_nxt = slots_used_r;
    nfw_nxt        = nfw_r;
    if (cmd.exec && alloc_ok) begin
      slots_used_nxt = slots_used_r + 1'b1;
      nfw_nxt        = NW'(CW'(nfw_r) + CW'(len_r));
    end
  end

  bah_ram #(
    .WIDTH (SEW),
    .DEPTH (MAX_ARRAYS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (cmd.exec && alloc_ok),
    .wr_addr (SW'(slots_used_r)),
    .wr_data (slot_wr),
    .rd_addr (SW'(rd_ref)),
    .rd_data (slot_rd)
  );

  bah_ram #(
    .WIDTH (bah_pkg::VAL_W),
    .DEPTH (HEAP_WORDS)
  ) u_elem_ram (
    .clk     (clk),
    .wr_en   (cmd.exec && store_ok),
    .wr_addr (addr_sum[AW-1:0]),
    .wr_data (val_r),
    .rd_addr (addr_sum[AW-1:0]),
    .rd_data (elem_rd)
  );

  assign out_data = out_data_r;

endmodule

[rtl/bounded_array_heap.sv]
// Top level of the array heap: controller and datapath joined by command and status.
//
// Each beat on the input side is one allocate, store or load, answered by exactly
// one result beat. An allocate or a store reaches the result register from the
// lookup state and a load from the access state after it, each once the result
// register is free: the slot table is a memory with a registered read, and a load
// then needs a second registered read of the word memory at base plus index. One
// item is in work at a time: a new beat is accepted only in the idle state, in the
// cycle after the previous result has reached the result register, even while
// that result still waits to be taken. Nothing is cleared after reset: slots are
// only used once they have been written, a load of a word never stored returns
// whatever the memory holds, and the counters reset at once.
module bounded_array_heap #(
  parameter int MAX_ARRAYS = 64,
  parameter int HEAP_WORDS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // array_ref [5:0], element_index [37:6], alloc_length [50:38],
  // store_value [82:51], zeros [87:83]
  input  logic [bah_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op [1:0]
  input  logic [bah_pkg::OP_W-1:0]           in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // new_ref [5:0], load_value [37:6], status [39:38]
  output logic [bah_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  bah_pkg::bah_cmd_t cmd;
  bah_pkg::bah_sts_t sts;

  bah_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bah_dp #(
    .MAX_ARRAYS (MAX_ARRAYS),
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_op    (in_tuser),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule
